### src/swmd_pkg.sv
// Shared types and constants for the sliding-window median deviation block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package swmd_pkg;

    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int CFG_W           = 11;
    localparam int COST_W          = 41;
    localparam int IN_TDATA_W      = 32;
    localparam int OUT_TDATA_W     = 48;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // latch the incoming sample and flag
        logic rm_start;   // capture the evicted value, reset the scan
        logic rm_rd;      // read sorted entry at the scan index
        logic rm_ex;      // compare or shift one entry down
        logic ins_start;  // set the insert position, grow the fill count if not full
        logic ins_rd;     // read the entry below the insert position
        logic ins_ex;     // shift one entry up or place the sample
        logic ins_put;    // place the sample at the bottom slot
        logic sum_start;  // clear the half sums and the index
        logic sum_rd;     // read sorted entry at the sum index
        logic sum_ex;     // accumulate one entry
        logic finish;     // write the ring, advance, emit the result
    } swmd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;       // window holds k samples
        logic idx_last;   // index is at k-1
        logic idx_zero;   // index is zero
        logic ins_gt;     // read entry is greater than the sample
        logic out_busy;   // result register holds a result not taken
    } swmd_status_t;

endpackage

`default_nettype wire

### src/swmd_ctrl.sv
// Sequencing state machine for the sliding-window median deviation block.
// Depends on swmd_pkg for the command and status structs.
`default_nettype none

module swmd_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire swmd_pkg::swmd_status_t st,
    output swmd_pkg::swmd_cmd_t         cmd
);
    import swmd_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_START    = 11'b000_0000_0010,
        S_RM_RD    = 11'b000_0000_0100,
        S_RM_EX    = 11'b000_0000_1000,
        S_INS_INIT = 11'b000_0001_0000,
        S_INS_RD   = 11'b000_0010_0000,
        S_INS_EX   = 11'b000_0100_0000,
        S_SUM_INIT = 11'b000_1000_0000,
        S_SUM_RD   = 11'b001_0000_0000,
        S_SUM_EX   = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } swmd_state_t;

    swmd_state_t state_reg, state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Decide the next step and drive commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (st.full)
                begin
                    cmd.rm_start = 1'b1;
                    state_next   = S_RM_RD;
                end
                else
                begin
                    cmd.ins_start = 1'b1;
                    state_next    = S_INS_RD;
                end
            end
            S_RM_RD:
            begin
                cmd.rm_rd  = 1'b1;
                state_next = S_RM_EX;
            end
            S_RM_EX:
            begin
                cmd.rm_ex  = 1'b1;
                state_next = st.idx_last ? S_INS_INIT : S_RM_RD;
            end
            S_INS_INIT:
            begin
                cmd.ins_start = 1'b1;
                state_next    = S_INS_RD;
            end
            S_INS_RD:
            begin
                if (st.idx_zero)
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = st.full ? S_SUM_INIT : S_FINISH;
                end
                else
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = S_INS_EX;
                end
            end
            S_INS_EX:
            begin
                cmd.ins_ex = 1'b1;
                if (st.ins_gt)
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = st.full ? S_SUM_INIT : S_FINISH;
                end
            end
            S_SUM_INIT:
            begin
                cmd.sum_start = 1'b1;
                state_next    = S_SUM_RD;
            end
            S_SUM_RD:
            begin
                cmd.sum_rd = 1'b1;
                state_next = S_SUM_EX;
            end
            S_SUM_EX:
            begin
                cmd.sum_ex = 1'b1;
                state_next = st.idx_last ? S_FINISH : S_SUM_RD;
            end
            S_FINISH:
            begin
                if (!(st.full && st.out_busy))
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Input is only taken while idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");

    // A load always leads to the start step
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_START))
        else $error("load did not reach start");

    // Finish leaves the controller idle
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE))
        else $error("finish did not return to idle");

endmodule

`default_nettype wire

### src/swmd_dp.sv
// Datapath: delay ring, sorted store, half sums and result register.
// Depends on swmd_pkg; driven by swmd_ctrl through command and status structs.
`default_nettype none

module swmd_dp #(
    parameter int WINDOW_MAX  = swmd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wen,
    input  wire logic [swmd_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic [SAMPLE_BITS-1:0]         in_sample,
    input  wire logic                           in_last,
    input  wire swmd_pkg::swmd_cmd_t            cmd,
    output swmd_pkg::swmd_status_t              st,
    output logic [swmd_pkg::COST_W-1:0]         out_cost,
    output logic                                out_end,
    output logic                                out_valid,
    input  wire logic                           out_ready
);
    import swmd_pkg::*;

    localparam int AW   = $clog2(WINDOW_MAX);
    localparam int KW   = $clog2(WINDOW_MAX + 1);
    localparam int SUMW = SAMPLE_BITS + KW + 1;
    localparam int CW   = (SUMW > COST_W) ? SUMW : COST_W;

    logic [CFG_W-1:0]              cfg_reg;
    logic [31:0]                   ws;
    logic [KW-1:0]                 k;
    logic [KW-1:0]                 k_m1;
    logic [KW-1:0]                 lower;

    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          last_reg;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic [KW-1:0]                 idx_reg;
    logic                          found_reg;
    logic [KW-1:0]                 fill_reg;
    logic [AW-1:0]                 rp_reg;
    logic signed [SUMW-1:0]        lsum_reg;
    logic signed [SUMW-1:0]        usum_reg;
    logic signed [SAMPLE_BITS-1:0] med_reg;

    logic signed [SAMPLE_BITS-1:0] sorted_mem [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] ring_mem   [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] sd_reg;
    logic signed [SAMPLE_BITS-1:0] rd_reg;

    logic                          s_we;
    logic [AW-1:0]                 s_waddr;
    logic signed [SAMPLE_BITS-1:0] s_wdata;
    logic [KW-1:0]                 s_raddr;

    logic                          full;
    logic                          emit;
    logic signed [SUMW-1:0]        cost;
    logic signed [CW-1:0]          cost_ext;
    logic                          out_valid_reg;
    logic [COST_W-1:0]             out_cost_reg;
    logic                          out_end_reg;

    // Effective window: zero acts as one, clamp at the maximum
    always_comb
    begin
        ws = 32'(cfg_reg);
        if (ws == 32'd0)
        begin
            k = KW'(1);
        end
        else if (ws > 32'(WINDOW_MAX))
        begin
            k = KW'(WINDOW_MAX);
        end
        else
        begin
            k = KW'(ws);
        end
    end

    assign k_m1  = k - KW'(1);
    assign lower = KW'((32'(k) + 32'd1) >> 1);
    assign full  = (fill_reg == k);

    assign st.full     = full;
    assign st.idx_last = (idx_reg == k_m1);
    assign st.idx_zero = (idx_reg == '0);
    assign st.ins_gt   = (sd_reg > x_reg);
    assign st.out_busy = out_valid_reg && !out_ready;

    // Sorted store write port selection
    always_comb
    begin
        s_we    = 1'b0;
        s_waddr = idx_reg[AW-1:0];
        s_wdata = x_reg;
        if (cmd.rm_ex && found_reg)
        begin
            s_we    = 1'b1;
            s_waddr = AW'(idx_reg - KW'(1));
            s_wdata = sd_reg;
        end
        else if (cmd.ins_put)
        begin
            s_we    = 1'b1;
            s_waddr = '0;
        end
        else if (cmd.ins_ex)
        begin
            s_we    = 1'b1;
            s_wdata = st.ins_gt ? sd_reg : x_reg;
        end
    end

    assign s_raddr = cmd.ins_rd ? (idx_reg - KW'(1)) : idx_reg;

    // Sorted store; hold the read data until the next read step
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            sorted_mem[s_waddr] <= s_wdata;
        end
        if (cmd.rm_rd || cmd.ins_rd || cmd.sum_rd)
        begin
            sd_reg <= sorted_mem[s_raddr[AW-1:0]];
        end
    end

    // Delay ring
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            ring_mem[rp_reg] <= x_reg;
        end
        rd_reg <= ring_mem[rp_reg];
    end

    // Sample, eviction and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= in_sample;
            last_reg <= in_last;
        end
        if (cmd.rm_start)
        begin
            old_reg   <= rd_reg;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        if (cmd.rm_ex)
        begin
            if (!found_reg && (sd_reg == old_reg))
            begin
                found_reg <= 1'b1;
            end
            idx_reg <= idx_reg + KW'(1);
        end
        if (cmd.ins_start)
        begin
            idx_reg <= full ? k_m1 : fill_reg;
        end
        if (cmd.ins_ex && st.ins_gt)
        begin
            idx_reg <= idx_reg - KW'(1);
        end
        if (cmd.sum_start)
        begin
            idx_reg  <= '0;
            lsum_reg <= '0;
            usum_reg <= '0;
        end
        if (cmd.sum_ex)
        begin
            if (idx_reg < lower)
            begin
                lsum_reg <= lsum_reg + SUMW'(sd_reg);
            end
            else
            begin
                usum_reg <= usum_reg + SUMW'(sd_reg);
            end
            if (idx_reg == (lower - KW'(1)))
            begin
                med_reg <= sd_reg;
            end
            idx_reg <= idx_reg + KW'(1);
        end
    end

    // Configuration, fill count and ring pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= CFG_W'(1);
            fill_reg <= '0;
            rp_reg   <= '0;
        end
        else if (cfg_wen)
        begin
            cfg_reg  <= cfg_wdata;
            fill_reg <= '0;
            rp_reg   <= '0;
        end
        else
        begin
            if (cmd.ins_start && !full)
            begin
                fill_reg <= fill_reg + KW'(1);
            end
            if (cmd.finish)
            begin
                if (last_reg)
                begin
                    fill_reg <= '0;
                    rp_reg   <= '0;
                end
                else if (KW'(rp_reg) == k_m1)
                begin
                    rp_reg <= '0;
                end
                else
                begin
                    rp_reg <= rp_reg + AW'(1);
                end
            end
        end
    end

    // Upper sum minus lower sum, plus the median for an odd window
    assign cost     = usum_reg - lsum_reg + (k[0] ? SUMW'(med_reg) : SUMW'(0));
    assign cost_ext = CW'(cost);
    assign emit     = cmd.finish && full;

    // Result register: hold until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_cost_reg <= cost_ext[COST_W-1:0];
            out_end_reg  <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_cost  = out_cost_reg;
    assign out_end   = out_end_reg;

    // Fill count never exceeds the window
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= k)
        else $error("fill count beyond window");

    // Ring pointer stays inside the window
    a_rp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        KW'(rp_reg) < k)
        else $error("ring pointer beyond window");

    // A result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten");

endmodule

`default_nettype wire

### src/sliding_window_median_deviation_top.sv
// Throughput: one sample in flight at a time; s_axis_tready is high only while idle.
// With a full window a sample passes through an eviction scan, an insertion shift and a
// sum sweep, with control steps between them; while the window fills, only the insertion
// shift runs. The result register is loaded in the finish step; with a full window that
// step waits while an earlier result is not taken.
// Reset (rst_n, async, active low) sets the window to one and empties it.
`default_nettype none

module sliding_window_median_deviation_top #(
    parameter int WINDOW_MAX  = swmd_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = swmd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wen,
    input  wire logic [swmd_pkg::CFG_W-1:0]       cfg_wdata,   // window_size
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [swmd_pkg::IN_TDATA_W-1:0]  s_axis_tdata, // [31:0] sample
    input  wire logic                             s_axis_tlast, // last_sample
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [swmd_pkg::OUT_TDATA_W-1:0]      m_axis_tdata, // [40:0] window_cost
    output logic                                  m_axis_tlast  // sequence_end
);
    import swmd_pkg::*;

    swmd_cmd_t         cmd;
    swmd_status_t      st;
    logic [COST_W-1:0] cost;

    swmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    swmd_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_last   (s_axis_tlast),
        .cmd       (cmd),
        .st        (st),
        .out_cost  (cost),
        .out_end   (m_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    // Pad the cost to whole bytes
    assign m_axis_tdata = OUT_TDATA_W'(cost);

endmodule

`default_nettype wire
